// ===== design/atapio_pkg.sv =====
// Shared types and constants for the ATA PIO LBA28 sector sequencer.
// Used by atapio_front, atapio_queue, atapio_back and the top level; no dependencies.
`default_nettype none

package atapio_pkg;

    // Sizing of the request fields and of the internal counters.
    localparam int unsigned LBA_W           = 28;
    localparam int unsigned COUNT_W         = 32;
    localparam int unsigned POLL_W          = 16;
    localparam int unsigned DATA_W          = 16;
    localparam int unsigned CHUNK_W         = 9;   // holds a chunk of up to 256 sectors
    localparam int unsigned WORDS_W         = 17;  // words in one chunk, up to 65536
    localparam int unsigned WORDS_SHIFT     = 8;   // 256 data words per sector

    localparam int unsigned MAX_CHUNK_DEF   = 256;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [POLL_W-1:0] POLL_LIMIT_RST = 16'd3000;

    // Input item codes.
    localparam logic [2:0] FN_START       = 3'd0;
    localparam logic [2:0] FN_BUS_ANSWER  = 3'd1;
    localparam logic [2:0] FN_HOST_WORD   = 3'd2;
    localparam logic [2:0] FN_IRQ         = 3'd3;
    localparam logic [2:0] FN_TICK        = 3'd4;

    // Result item kinds.
    localparam logic [2:0] K_REG_WRITE    = 3'd0;
    localparam logic [2:0] K_REG_READ     = 3'd1;
    localparam logic [2:0] K_HOST_WORD    = 3'd2;
    localparam logic [2:0] K_NEED_WORD    = 3'd3;
    localparam logic [2:0] K_DONE         = 3'd4;
    localparam logic [2:0] K_FAILED       = 3'd5;

    // Task file register offsets.
    localparam logic [2:0] REG_DATA       = 3'd0;
    localparam logic [2:0] REG_SECCNT     = 3'd2;
    localparam logic [2:0] REG_LBA_LO     = 3'd3;
    localparam logic [2:0] REG_LBA_MID    = 3'd4;
    localparam logic [2:0] REG_LBA_HI     = 3'd5;
    localparam logic [2:0] REG_DEVICE     = 3'd6;
    localparam logic [2:0] REG_CMD_STATUS = 3'd7;

    // Status bits, device register and command bytes.
    localparam logic [7:0] ST_BSY         = 8'h80;
    localparam logic [7:0] ST_DRQ         = 8'h08;
    localparam logic [7:0] DEV_BASE       = 8'hE0;  // fixed ones plus LBA mode
    localparam logic [7:0] DEV_SLAVE      = 8'h10;
    localparam logic [7:0] CMD_READ       = 8'h20;
    localparam logic [7:0] CMD_WRITE      = 8'h30;

    // One queued job: an optional head result, an optional six-write chunk
    // command, and an optional tail result, emitted in that order.
    typedef struct packed {
        logic              has_head;
        logic [2:0]        head_kind;
        logic [DATA_W-1:0] head_value;
        logic              has_chunk;
        logic [7:0]        chunk_byte;
        logic [LBA_W-1:0]  lba;
        logic              drive;
        logic              write_mode;
        logic              has_tail;
        logic [2:0]        tail_kind;
        logic [2:0]        tail_offset;
    } t_job;

endpackage

`default_nettype wire

// ===== design/atapio_front.sv =====
// Front part of the sequencer: accepts input items, keeps the transfer state
// and turns each item into one job descriptor. Depends on atapio_pkg.
`default_nettype none

module atapio_front #(
    parameter int unsigned MAX_CHUNK = atapio_pkg::MAX_CHUNK_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [15:0]               i_cfg_wdata,
    input  logic                      i_accept,
    input  logic [2:0]                i_func,
    input  logic                      i_drive,
    input  logic [27:0]               i_lba,
    input  logic [31:0]               i_sector_count,
    input  logic                      i_is_write,
    input  logic [15:0]               i_read_data,
    output logic                      o_push,
    output atapio_pkg::t_job          o_job
);
    import atapio_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_IRQ,
        PH_ACK,
        PH_POLL_WAIT,
        PH_POLL_SLEEP,
        PH_DATA_RD,
        PH_DATA_WR
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [POLL_W-1:0]   r_poll_limit;
    logic                r_drive_sel, n_drive_sel;
    logic                r_write_mode, n_write_mode;
    logic [LBA_W-1:0]    r_next_lba, n_next_lba;
    logic [COUNT_W-1:0]  r_sectors_left, n_sectors_left;
    logic [WORDS_W-1:0]  r_words_left, n_words_left;
    logic [POLL_W-1:0]   r_polls_left, n_polls_left;
    logic                r_expect_irq, n_expect_irq;

    logic                is_start;
    logic [COUNT_W-1:0]  src_count;
    logic [LBA_W-1:0]    src_lba;
    logic                src_drive;
    logic                src_wmode;
    logic [CHUNK_W-1:0]  chunk;
    logic [COUNT_W-1:0]  iss_left;
    logic [LBA_W-1:0]    iss_lba;
    logic [WORDS_W-1:0]  iss_words;
    logic [WORDS_W-1:0]  words_dec;
    logic                do_issue;
    logic                do_poll_start;
    logic                do_clear;
    t_job                job;

    // A chunk is issued either straight from a start item or from the stored state.
    assign is_start  = (i_func == FN_START) && (r_phase == PH_IDLE);
    assign src_count = is_start ? i_sector_count : r_sectors_left;
    assign src_lba   = is_start ? i_lba : r_next_lba;
    assign src_drive = is_start ? i_drive : r_drive_sel;
    assign src_wmode = is_start ? i_is_write : r_write_mode;

    assign chunk     = (src_count < COUNT_W'(MAX_CHUNK)) ? src_count[CHUNK_W-1:0]
                                                         : CHUNK_W'(MAX_CHUNK);
    assign iss_left  = src_count - COUNT_W'(chunk);
    assign iss_lba   = src_lba + LBA_W'(chunk);
    assign iss_words = WORDS_W'(chunk) << WORDS_SHIFT;
    assign words_dec = (r_words_left == '0) ? '0 : r_words_left - WORDS_W'(1);

    always_comb begin
        n_phase        = r_phase;
        n_drive_sel    = r_drive_sel;
        n_write_mode   = r_write_mode;
        n_next_lba     = r_next_lba;
        n_sectors_left = r_sectors_left;
        n_words_left   = r_words_left;
        n_polls_left   = r_polls_left;
        n_expect_irq   = r_expect_irq;
        do_issue       = 1'b0;
        do_poll_start  = 1'b0;
        do_clear       = 1'b0;

        job            = '0;
        job.chunk_byte = chunk[7:0];
        job.lba        = src_lba;
        job.drive      = src_drive;
        job.write_mode = src_wmode;

        unique case (i_func)
            FN_START: begin
                if (r_phase == PH_IDLE) begin
                    n_drive_sel  = i_drive;
                    n_write_mode = i_is_write;
                    if (i_sector_count == '0) begin
                        do_clear      = 1'b1;
                        job.has_tail  = 1'b1;
                        job.tail_kind = K_FAILED;
                    end else begin
                        do_issue = 1'b1;
                    end
                end
            end
            FN_BUS_ANSWER: begin
                unique case (r_phase)
                    PH_ACK: begin
                        if (!r_write_mode) begin
                            do_poll_start = 1'b1;
                        end else if (r_sectors_left == '0) begin
                            do_clear      = 1'b1;
                            job.has_tail  = 1'b1;
                            job.tail_kind = K_DONE;
                        end else begin
                            do_issue = 1'b1;
                        end
                    end
                    PH_POLL_WAIT: begin
                        if ((i_read_data[7:0] & ST_BSY) != 8'h00) begin
                            if (r_polls_left == '0) begin
                                do_clear      = 1'b1;
                                job.has_tail  = 1'b1;
                                job.tail_kind = K_FAILED;
                            end else begin
                                n_polls_left = r_polls_left - POLL_W'(1);
                                n_phase      = PH_POLL_SLEEP;
                            end
                        end else if ((i_read_data[7:0] & ST_DRQ) != 8'h00) begin
                            job.has_tail    = 1'b1;
                            job.tail_offset = REG_DATA;
                            if (r_write_mode) begin
                                n_phase       = PH_DATA_WR;
                                job.tail_kind = K_NEED_WORD;
                            end else begin
                                n_phase       = PH_DATA_RD;
                                job.tail_kind = K_REG_READ;
                            end
                        end else begin
                            do_clear      = 1'b1;
                            job.has_tail  = 1'b1;
                            job.tail_kind = K_FAILED;
                        end
                    end
                    PH_DATA_RD: begin
                        job.has_head   = 1'b1;
                        job.head_kind  = K_HOST_WORD;
                        job.head_value = i_read_data;
                        n_words_left   = words_dec;
                        if (words_dec != '0) begin
                            job.has_tail    = 1'b1;
                            job.tail_kind   = K_REG_READ;
                            job.tail_offset = REG_DATA;
                        end else if (r_sectors_left == '0) begin
                            do_clear      = 1'b1;
                            job.has_tail  = 1'b1;
                            job.tail_kind = K_DONE;
                        end else begin
                            do_issue = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            FN_HOST_WORD: begin
                if (r_phase == PH_DATA_WR) begin
                    job.has_head   = 1'b1;
                    job.head_kind  = K_REG_WRITE;
                    job.head_value = i_read_data;
                    n_words_left   = words_dec;
                    if (words_dec != '0) begin
                        job.has_tail    = 1'b1;
                        job.tail_kind   = K_NEED_WORD;
                        job.tail_offset = REG_DATA;
                    end else begin
                        n_phase = PH_WAIT_IRQ;
                    end
                end
            end
            FN_IRQ: begin
                if ((r_phase == PH_WAIT_IRQ) && r_expect_irq) begin
                    n_expect_irq    = 1'b0;
                    n_phase         = PH_ACK;
                    job.has_tail    = 1'b1;
                    job.tail_kind   = K_REG_READ;
                    job.tail_offset = REG_CMD_STATUS;
                end
            end
            FN_TICK: begin
                if (r_phase == PH_POLL_SLEEP) begin
                    n_phase         = PH_POLL_WAIT;
                    job.has_tail    = 1'b1;
                    job.tail_kind   = K_REG_READ;
                    job.tail_offset = REG_CMD_STATUS;
                end
            end
            default: begin
            end
        endcase

        if (do_issue) begin
            job.has_chunk  = 1'b1;
            n_sectors_left = iss_left;
            n_next_lba     = iss_lba;
            n_words_left   = iss_words;
            n_expect_irq   = 1'b1;
            if (src_wmode) begin
                do_poll_start = 1'b1;
            end else begin
                n_phase = PH_WAIT_IRQ;
            end
        end

        if (do_poll_start) begin
            n_polls_left    = r_poll_limit;
            n_phase         = PH_POLL_WAIT;
            job.has_tail    = 1'b1;
            job.tail_kind   = K_REG_READ;
            job.tail_offset = REG_CMD_STATUS;
        end

        if (do_clear) begin
            n_phase        = PH_IDLE;
            n_sectors_left = '0;
            n_words_left   = '0;
            n_polls_left   = '0;
            n_expect_irq   = 1'b0;
        end
    end

    assign o_job  = job;
    assign o_push = i_accept && (job.has_head || job.has_chunk || job.has_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_poll_limit   <= POLL_LIMIT_RST;
            r_sectors_left <= '0;
            r_words_left   <= '0;
            r_polls_left   <= '0;
            r_expect_irq   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_poll_limit <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_phase        <= n_phase;
                r_sectors_left <= n_sectors_left;
                r_words_left   <= n_words_left;
                r_polls_left   <= n_polls_left;
                r_expect_irq   <= n_expect_irq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_drive_sel  <= n_drive_sel;
            r_write_mode <= n_write_mode;
            r_next_lba   <= n_next_lba;
        end
    end

    // Leaving a transfer always clears the word count and the interrupt flag.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> ((r_words_left == '0) && !r_expect_irq))
        else $error("idle phase with transfer state left over");

    // A data phase is only ever entered with words still to move.
    a_data_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_DATA_RD) || (r_phase == PH_DATA_WR)) |-> (r_words_left != '0))
        else $error("data phase with no words left");

endmodule

`default_nettype wire

// ===== design/atapio_queue.sv =====
// Short job queue between the front and back parts of the sequencer.
// Holds t_job descriptors in registers; depends on atapio_pkg.
`default_nettype none

module atapio_queue #(
    parameter int unsigned DEPTH = atapio_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  atapio_pkg::t_job  i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output atapio_pkg::t_job  o_job
);
    import atapio_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job popped from an empty queue");

endmodule

`default_nettype wire

// ===== design/atapio_back.sv =====
// Back part of the sequencer: expands the job at the head of the queue into result
// items, one per cycle unless stalled, through an output register. Depends on atapio_pkg.
`default_nettype none

module atapio_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  atapio_pkg::t_job  i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_kind,
    output logic [2:0]        o_reg_offset,
    output logic [15:0]       o_value,
    output logic              o_last
);
    import atapio_pkg::*;

    logic [7:0]  r_done;
    logic        r_out_valid;
    logic [2:0]  r_out_kind;
    logic [2:0]  r_out_offset;
    logic [15:0] r_out_value;
    logic        r_out_last;

    logic [7:0]  mask;
    logic [7:0]  pending;
    logic [7:0]  cur_onehot;
    logic [2:0]  slot;
    logic        last;
    logic        emit;
    logic [2:0]  s_kind;
    logic [2:0]  s_offset;
    logic [15:0] s_value;

    // Slot 0 is the head result, slots 1 to 6 the chunk command writes, slot 7 the tail.
    assign mask       = {i_job.has_tail, {6{i_job.has_chunk}}, i_job.has_head};
    assign pending    = mask & ~r_done;
    assign cur_onehot = pending & (~pending + 8'd1);
    assign last       = ((pending & ~cur_onehot) == 8'h00);
    assign emit       = i_q_valid && (!r_out_valid || !i_stall);
    assign o_pop      = emit && last;

    always_comb begin
        slot = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (pending[i]) begin
                slot = 3'(i);
            end
        end
    end

    always_comb begin
        unique case (slot)
            3'd0: begin
                s_kind   = i_job.head_kind;
                s_offset = REG_DATA;
                s_value  = i_job.head_value;
            end
            3'd1: begin
                s_kind   = K_REG_WRITE;
                s_offset = REG_SECCNT;
                s_value  = {8'h00, i_job.chunk_byte};
            end
            3'd2: begin
                s_kind   = K_REG_WRITE;
                s_offset = REG_LBA_LO;
                s_value  = {8'h00, i_job.lba[7:0]};
            end
            3'd3: begin
                s_kind   = K_REG_WRITE;
                s_offset = REG_LBA_MID;
                s_value  = {8'h00, i_job.lba[15:8]};
            end
            3'd4: begin
                s_kind   = K_REG_WRITE;
                s_offset = REG_LBA_HI;
                s_value  = {8'h00, i_job.lba[23:16]};
            end
            3'd5: begin
                s_kind   = K_REG_WRITE;
                s_offset = REG_DEVICE;
                s_value  = {8'h00, DEV_BASE | (i_job.drive ? DEV_SLAVE : 8'h00)
                                   | {4'h0, i_job.lba[27:24]}};
            end
            3'd6: begin
                s_kind   = K_REG_WRITE;
                s_offset = REG_CMD_STATUS;
                s_value  = {8'h00, i_job.write_mode ? CMD_WRITE : CMD_READ};
            end
            3'd7: begin
                s_kind   = i_job.tail_kind;
                s_offset = i_job.tail_offset;
                s_value  = 16'h0000;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_done      <= last ? 8'h00 : (r_done | cur_onehot);
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind   <= s_kind;
            r_out_offset <= s_offset;
            r_out_value  <= s_value;
            r_out_last   <= last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_reg_offset = r_out_offset;
    assign o_value      = r_out_value;
    assign o_last       = r_out_last;

    // A job leaves the queue only together with the result that closes it.
    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_out_valid && r_out_last))
        else $error("job retired without a last result");

    // Partly emitted jobs stay at the head of the queue.
    a_partial_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done != 8'h00) |-> i_q_valid)
        else $error("partly emitted job lost from the queue");

endmodule

`default_nettype wire

// ===== design/ata_pio_sector_sequencer_top.sv =====
// Top level of the ATA PIO LBA28 sector sequencer.
// Instantiates atapio_front, atapio_queue and atapio_back; depends on atapio_pkg.
//
// Usage: the input channel (i_valid / o_stall) carries items that start a
// request, answer a bus read, supply a host word, signal the interrupt or a
// poll tick. The output channel (o_valid / i_stall) carries result items:
// task file writes and reads, words for the host, requests for host words, and
// done or failed. o_last marks the final result caused by one input item; an
// item that causes nothing gives no result at all.
// The front part updates the transfer state in the cycle an item is accepted
// and queues one job describing that item's results. The back part turns each
// job into results through an output register, one per cycle while the receiver
// does not stall; the first result passes through the job queue and then the
// output register. An item accepts every cycle while the job queue has room;
// each result takes the output register in turn, up to two for a streamed data
// word and up to 7 when a new chunk is commanded.
// When the receiver stalls, the output register holds its result, the back
// part waits, and the input side keeps accepting until the queue is full, at
// which point o_stall rises. Reset is synchronous, active low: the sequencer
// returns to idle, the queue empties and poll_limit returns to 3000 ticks.
// The user must write poll_limit via i_cfg_we only while idle; nothing checks it.
`default_nettype none

module ata_pio_sector_sequencer_top #(
    parameter int unsigned MAX_CHUNK   = atapio_pkg::MAX_CHUNK_DEF,
    parameter int unsigned QUEUE_DEPTH = atapio_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic        i_drive,
    input  logic [27:0] i_lba,
    input  logic [31:0] i_sector_count,
    input  logic        i_is_write,
    input  logic [15:0] i_read_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_reg_offset,
    output logic [15:0] o_value,
    output logic        o_last
);
    import atapio_pkg::*;

    logic  q_full;
    logic  q_valid;
    logic  push;
    logic  pop;
    logic  accept;
    t_job  front_job;
    t_job  head_job;

    // The input side stalls only when the job queue has no room left.
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    atapio_front #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (accept),
        .i_func         (i_func),
        .i_drive        (i_drive),
        .i_lba          (i_lba),
        .i_sector_count (i_sector_count),
        .i_is_write     (i_is_write),
        .i_read_data    (i_read_data),
        .o_push         (push),
        .o_job          (front_job)
    );

    atapio_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    atapio_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_job        (head_job),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_reg_offset (o_reg_offset),
        .o_value      (o_value),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// ===== tb/ata_pio_seq_checker.sv =====
// Scoreboard for the ATA PIO sector sequencer: watches both channels and the poll_limit port.
// Keeps its own copy of the sequencer state and compares every result item in order.
// Depends on atapio_pkg for the item codes, register offsets and status bits.
module ata_pio_seq_checker
    import atapio_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_func,
    input  logic        i_drive,
    input  logic [27:0] i_lba,
    input  logic [31:0] i_sector_count,
    input  logic        i_is_write,
    input  logic [15:0] i_read_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_kind,
    input  logic [2:0]  i_reg_offset,
    input  logic [15:0] i_value,
    input  logic        i_last,
    output int          o_errors,
    output int          o_pending
);

    localparam logic [2:0]  NO_OFFSET  = 3'd0;
    localparam logic [15:0] NO_VALUE   = 16'h0000;
    localparam int          PRINT_CAP  = 100;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_WAIT_IRQ,
        PH_ACK,
        PH_POLL_WAIT,
        PH_POLL_SLEEP,
        PH_DATA_RD,
        PH_DATA_WR
    } seq_phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  reg_offset;
        logic [15:0] value;
        logic        last;
    } bus_op_t;

    logic [15:0] poll_limit;
    seq_phase_t  phase;
    logic        drive_sel;
    logic        write_mode;
    logic [27:0] next_lba;
    logic [31:0] sectors_left;
    logic [16:0] words_left;
    logic [15:0] polls_left;
    logic        irq_armed;

    bus_op_t step_ops[$];
    bus_op_t expected_ops[$];
    bus_op_t seen_op;
    bus_op_t want_op;
    int      error_count = 0;

    function automatic void emit(input logic [2:0] kind, input logic [2:0] off,
                                 input logic [15:0] val);
        step_ops.push_back('{kind, off, val, 1'b0});
    endfunction

    function automatic void clear_transfer();
        phase        = PH_IDLE;
        sectors_left = '0;
        words_left   = '0;
        polls_left   = '0;
        irq_armed    = 1'b0;
    endfunction

    function automatic void fail_transfer();
        clear_transfer();
        emit(K_FAILED, NO_OFFSET, NO_VALUE);
    endfunction

    function automatic void start_poll();
        polls_left = poll_limit;
        phase      = PH_POLL_WAIT;
        emit(K_REG_READ, REG_CMD_STATUS, NO_VALUE);
    endfunction

    // Commands the next chunk of at most 256 sectors; a full chunk is written as count 0.
    function automatic void issue_chunk();
        logic [8:0]  chunk;
        logic [27:0] addr;
        logic [7:0]  dev;
        chunk = (sectors_left < 32'd256) ? sectors_left[8:0] : 9'd256;
        addr  = next_lba;
        dev   = DEV_BASE | (drive_sel ? DEV_SLAVE : 8'h00) | {4'h0, addr[27:24]};
        emit(K_REG_WRITE, REG_SECCNT, {8'h00, chunk[7:0]});
        emit(K_REG_WRITE, REG_LBA_LO, {8'h00, addr[7:0]});
        emit(K_REG_WRITE, REG_LBA_MID, {8'h00, addr[15:8]});
        emit(K_REG_WRITE, REG_LBA_HI, {8'h00, addr[23:16]});
        emit(K_REG_WRITE, REG_DEVICE, {8'h00, dev});
        emit(K_REG_WRITE, REG_CMD_STATUS, {8'h00, write_mode ? CMD_WRITE : CMD_READ});
        sectors_left = sectors_left - 32'(chunk);
        next_lba     = addr + 28'(chunk);
        words_left   = {chunk, 8'h00};
        irq_armed    = 1'b1;
        if (write_mode) begin
            start_poll();
        end else begin
            phase = PH_WAIT_IRQ;
        end
    endfunction

    function automatic void finish_chunk();
        if (sectors_left == 0) begin
            clear_transfer();
            emit(K_DONE, NO_OFFSET, NO_VALUE);
        end else begin
            issue_chunk();
        end
    endfunction

    function automatic void advance_sequencer(input logic [2:0] func, input logic drv,
                                              input logic [27:0] lba, input logic [31:0] count,
                                              input logic wr, input logic [15:0] data);
        case (func)
            FN_START: begin
                if (phase == PH_IDLE) begin
                    drive_sel    = drv;
                    next_lba     = lba;
                    sectors_left = count;
                    write_mode   = wr;
                    if (count == 0) begin
                        fail_transfer();
                    end else begin
                        issue_chunk();
                    end
                end
            end
            FN_BUS_ANSWER: begin
                if (phase == PH_ACK) begin
                    if (write_mode) begin
                        finish_chunk();
                    end else begin
                        start_poll();
                    end
                end else if (phase == PH_POLL_WAIT) begin
                    if ((data & {8'h00, ST_BSY}) != 0) begin
                        if (polls_left == 0) begin
                            fail_transfer();
                        end else begin
                            polls_left = polls_left - 1'b1;
                            phase      = PH_POLL_SLEEP;
                        end
                    end else if ((data & {8'h00, ST_DRQ}) != 0) begin
                        if (write_mode) begin
                            phase = PH_DATA_WR;
                            emit(K_NEED_WORD, NO_OFFSET, NO_VALUE);
                        end else begin
                            phase = PH_DATA_RD;
                            emit(K_REG_READ, REG_DATA, NO_VALUE);
                        end
                    end else begin
                        fail_transfer();
                    end
                end else if (phase == PH_DATA_RD) begin
                    emit(K_HOST_WORD, NO_OFFSET, data);
                    if (words_left != 0) words_left = words_left - 1'b1;
                    if (words_left != 0) begin
                        emit(K_REG_READ, REG_DATA, NO_VALUE);
                    end else begin
                        finish_chunk();
                    end
                end
            end
            FN_HOST_WORD: begin
                if (phase == PH_DATA_WR) begin
                    emit(K_REG_WRITE, REG_DATA, data);
                    if (words_left != 0) words_left = words_left - 1'b1;
                    if (words_left != 0) begin
                        emit(K_NEED_WORD, NO_OFFSET, NO_VALUE);
                    end else begin
                        phase = PH_WAIT_IRQ;
                    end
                end
            end
            FN_IRQ: begin
                if (phase == PH_WAIT_IRQ && irq_armed) begin
                    irq_armed = 1'b0;
                    phase     = PH_ACK;
                    emit(K_REG_READ, REG_CMD_STATUS, NO_VALUE);
                end
            end
            FN_TICK: begin
                if (phase == PH_POLL_SLEEP) begin
                    phase = PH_POLL_WAIT;
                    emit(K_REG_READ, REG_CMD_STATUS, NO_VALUE);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input bus_op_t seen, input bus_op_t want);
        // Everything is counted, but only the first mismatches are printed.
        if (error_count < PRINT_CAP) begin
            $display("mismatch at %0t: %s: got kind %0d reg %0d value %h last %b, want kind %0d reg %0d value %h last %b",
                     $realtime, what, seen.kind, seen.reg_offset, seen.value, seen.last,
                     want.kind, want.reg_offset, want.value, want.last);
        end
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            poll_limit = POLL_LIMIT_RST;
            drive_sel  = 1'b0;
            write_mode = 1'b0;
            next_lba   = '0;
            clear_transfer();
            expected_ops.delete();
        end else begin
            if (i_cfg_we) poll_limit = i_cfg_wdata;

            // A result can never belong to an item accepted at the same edge,
            // so results are checked before the new item is predicted.
            if (i_out_valid && !i_out_stall) begin
                seen_op = '{i_kind, i_reg_offset, i_value, i_last};
                if (expected_ops.size() == 0) begin
                    report_mismatch("result with nothing expected", seen_op, '0);
                end else begin
                    want_op = expected_ops.pop_front();
                    if (seen_op.kind !== want_op.kind ||
                        seen_op.reg_offset !== want_op.reg_offset ||
                        seen_op.value !== want_op.value ||
                        seen_op.last !== want_op.last) begin
                        report_mismatch("wrong result", seen_op, want_op);
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                step_ops.delete();
                advance_sequencer(i_func, i_drive, i_lba, i_sector_count, i_is_write, i_read_data);
                if (step_ops.size() > 0) begin
                    want_op = step_ops.pop_back();
                    want_op.last = 1'b1;
                    step_ops.push_back(want_op);
                end
                foreach (step_ops[k]) expected_ops.push_back(step_ops[k]);
            end
        end
        o_errors  <= error_count;
        o_pending <= expected_ops.size();
    end

endmodule

// ===== tb/tb_ata_pio_sector_sequencer_top.sv =====
// Testbench top for ata_pio_sector_sequencer_top: clock, reset, stimulus and the verdict.
// Drives whole read and write transfers with noise items, idling and stalls.
// Depends on atapio_pkg, the sequencer RTL and ata_pio_seq_checker.
module tb_ata_pio_sector_sequencer_top;
    import atapio_pkg::*;

    // The package names every input code but the idle one.
    localparam logic [2:0] FN_IDLE      = 3'd5;
    // Cycles without any accepted item before the run is declared hung. The
    // longest legal quiet stretch is the receiver hold-off below.
    localparam int         QUIET_LIMIT  = 2000;
    localparam int         HOLD_CYCLES  = 400;
    // Settling time once nothing is expected any more.
    localparam int         DRAIN_CYCLES = 20;

    typedef enum logic [1:0] {
        END_DONE,
        END_NO_DRQ,
        END_TIMEOUT
    } xfer_end_t;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [15:0] i_cfg_wdata    = '0;
    logic        i_valid        = 1'b0;
    logic        o_stall;
    logic [2:0]  i_func         = FN_IDLE;
    logic        i_drive        = 1'b0;
    logic [27:0] i_lba          = '0;
    logic [31:0] i_sector_count = '0;
    logic        i_is_write     = 1'b0;
    logic [15:0] i_read_data    = '0;
    logic        o_valid;
    logic        i_stall        = 1'b0;
    logic [2:0]  o_kind;
    logic [2:0]  o_reg_offset;
    logic [15:0] o_value;
    logic        o_last;

    // Knobs of the current phase, set by the main sequence.
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   cfg_poll_limit = 3000;
    logic pressure_on    = 1'b0;

    int hold_count   = 0;
    int quiet_cycles = 0;
    int mismatches;
    int pending;

    ata_pio_sector_sequencer_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_drive        (i_drive),
        .i_lba          (i_lba),
        .i_sector_count (i_sector_count),
        .i_is_write     (i_is_write),
        .i_read_data    (i_read_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_reg_offset   (o_reg_offset),
        .o_value        (o_value),
        .o_last         (o_last)
    );

    ata_pio_seq_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_func         (i_func),
        .i_drive        (i_drive),
        .i_lba          (i_lba),
        .i_sector_count (i_sector_count),
        .i_is_write     (i_is_write),
        .i_read_data    (i_read_data),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_kind         (o_kind),
        .i_reg_offset   (o_reg_offset),
        .i_value        (o_value),
        .i_last         (o_last),
        .o_errors       (mismatches),
        .o_pending      (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver side. Once pressure is switched on, it holds off for a long
    // stretch so that the job queue fills and the block stalls its input;
    // otherwise it stalls at random at the rate of the current phase.
    always @(posedge i_clk) begin
        if (pressure_on && hold_count < HOLD_CYCLES) begin
            i_stall    <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Counts cycles in which neither channel moved an item.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    // Offers one item and returns at the edge where it is accepted. The
    // payload stays put while the block stalls; a random gap comes first.
    task automatic offer_item(input logic [2:0] func, input logic drv, input logic [27:0] lba,
                              input logic [31:0] count, input logic wr, input logic [15:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= func;
        i_drive        <= drv;
        i_lba          <= lba;
        i_sector_count <= count;
        i_is_write     <= wr;
        i_read_data    <= data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Items other than a start only look at func and read_data, so the
    // remaining fields carry random bits.
    task automatic put_op(input logic [2:0] func, input logic [15:0] data);
        offer_item(func, 1'($urandom_range(0, 1)), 28'($urandom), $urandom,
                   1'($urandom_range(0, 1)), data);
    endtask

    // Every phase of the sequencer reacts to exactly one item code. Now and
    // then an item of any other code is slipped in; the block must ignore it.
    task automatic add_noise(input logic [2:0] awaited);
        logic [2:0] func;
        if ($urandom_range(0, 7) == 0) begin
            func = 3'($urandom_range(0, 5));
            while (func == awaited) func = 3'($urandom_range(0, 5));
            put_op(func, 16'($urandom));
        end
    endtask

    // Plays the drive side of one request: interrupt and acknowledge, busy
    // polls with ticks, then the data words, chunk by chunk. A transfer meant
    // to fail ends while polling in its first chunk, either on missing DRQ or
    // by running the poll budget dry.
    task automatic run_transfer(input logic drv, input logic [27:0] lba, input logic [31:0] count,
                                input logic wr, input xfer_end_t ending);
        logic [31:0] left;
        int          chunk;
        int          n_busy;
        int          i;
        int          w;
        left = count;
        add_noise(FN_START);
        offer_item(FN_START, drv, lba, count, wr, 16'($urandom));
        if (count == 0) return;
        while (left != 0) begin
            chunk = (left < 32'd256) ? int'(left) : 256;
            left  = left - 32'(chunk);
            // A read chunk opens with the interrupt; its status read is discarded.
            if (!wr) begin
                add_noise(FN_IRQ);
                put_op(FN_IRQ, 16'($urandom));
                add_noise(FN_BUS_ANSWER);
                put_op(FN_BUS_ANSWER, 16'($urandom));
            end
            if (ending == END_TIMEOUT) begin
                n_busy = cfg_poll_limit + 1;
            end else begin
                n_busy = $urandom_range(0, (cfg_poll_limit < 3) ? cfg_poll_limit : 3);
            end
            for (i = 0; i < n_busy; i++) begin
                add_noise(FN_BUS_ANSWER);
                put_op(FN_BUS_ANSWER, 16'($urandom) | {8'h00, ST_BSY});
                if (ending == END_TIMEOUT && i == n_busy - 1) return;
                add_noise(FN_TICK);
                put_op(FN_TICK, 16'($urandom));
            end
            add_noise(FN_BUS_ANSWER);
            if (ending == END_NO_DRQ) begin
                put_op(FN_BUS_ANSWER, 16'($urandom) & ~{8'h00, ST_BSY | ST_DRQ});
                return;
            end
            put_op(FN_BUS_ANSWER, (16'($urandom) & ~{8'h00, ST_BSY}) | {8'h00, ST_DRQ});
            for (w = 0; w < chunk * 256; w++) begin
                add_noise(wr ? FN_HOST_WORD : FN_BUS_ANSWER);
                put_op(wr ? FN_HOST_WORD : FN_BUS_ANSWER, 16'($urandom));
            end
            // A write chunk closes with the interrupt and its acknowledge.
            if (wr) begin
                add_noise(FN_IRQ);
                put_op(FN_IRQ, 16'($urandom));
                add_noise(FN_BUS_ANSWER);
                put_op(FN_BUS_ANSWER, 16'($urandom));
            end
        end
    endtask

    // Random requests: mostly complete one- or two-sector transfers, some
    // aborted ones with a random full-width count, and a few zero counts.
    task automatic run_phase(input int n_xfers);
        int          t;
        int          pick;
        logic [31:0] count;
        xfer_end_t   ending;
        for (t = 0; t < n_xfers; t++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                count  = 32'd0;
                ending = END_DONE;
            end else if (pick < 13) begin
                count  = ($urandom_range(0, 9) == 0) ? 32'd2 : 32'd1;
                ending = END_DONE;
            end else begin
                count  = $urandom;
                if (count == 0) count = 32'd1;
                ending = (pick < 16 || cfg_poll_limit > 4) ? END_NO_DRQ : END_TIMEOUT;
            end
            run_transfer(1'($urandom_range(0, 1)), 28'($urandom), count,
                         1'($urandom_range(0, 1)), ending);
        end
    endtask

    // Drops valid and waits until every expected result has come out, then a
    // little longer in case the block is still busy with an item that
    // causes nothing.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Moves to a new setting of poll_limit and of the idling rates. The
    // register is only written once the block has gone quiet.
    task automatic next_phase(input int limit, input int idle_pct, input int stall_pct);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= 16'(limit);
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        cfg_poll_limit = limit;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset value of poll_limit and with no idling.
        // A zero sector count fails at once and leaves the block idle.
        offer_item(FN_START, 1'b1, 28'hFFFFFFF, 32'h0, 1'b1, 16'hFFFF);
        // Interrupt, tick, bus answer, host word and idle are all ignored when idle.
        put_op(FN_IRQ, 16'h0000);
        put_op(FN_TICK, 16'h0000);
        put_op(FN_BUS_ANSWER, 16'hFFFF);
        put_op(FN_HOST_WORD, 16'hFFFF);
        put_op(FN_IDLE, 16'h0000);
        // Read on the slave at the top address with the largest count: a full
        // chunk, written as zero sectors, device byte with all LBA bits set.
        offer_item(FN_START, 1'b1, 28'hFFFFFFF, 32'hFFFFFFFF, 1'b0, 16'h0000);
        // A second start while busy is dropped.
        offer_item(FN_START, 1'b0, 28'h0000000, 32'h1, 1'b1, 16'h0000);
        put_op(FN_BUS_ANSWER, 16'hFFFF);
        put_op(FN_IRQ, 16'h0000);
        // A second interrupt during the acknowledge is not expected any more.
        put_op(FN_IRQ, 16'h0000);
        put_op(FN_BUS_ANSWER, 16'hFFFF);
        put_op(FN_TICK, 16'h0000);
        put_op(FN_BUS_ANSWER, 16'h0080);
        // A bus answer while sleeping between polls is dropped.
        put_op(FN_BUS_ANSWER, 16'h0008);
        put_op(FN_TICK, 16'h0000);
        // BSY clear and DRQ clear: the transfer fails on missing DRQ.
        put_op(FN_BUS_ANSWER, 16'hFF77);
        // Write on the master at address zero: polling starts right away,
        // BSY wins over DRQ, and then the drive answers with neither bit.
        offer_item(FN_START, 1'b0, 28'h0000000, 32'h80000000, 1'b1, 16'h0000);
        put_op(FN_BUS_ANSWER, 16'h0088);
        put_op(FN_TICK, 16'h0000);
        put_op(FN_BUS_ANSWER, 16'h0000);

        // Two chunks whose address wraps past the top of the LBA range.
        run_transfer(1'b0, 28'hFFFFFF0, 32'd257, 1'b0, END_DONE);
        run_phase(3);

        // Largest poll budget, sender idling heavily.
        next_phase(65535, 70, 0);
        run_phase(3);

        // Smallest legal budget, receiver stalling heavily.
        next_phase(1, 0, 70);
        run_transfer(1'($urandom_range(0, 1)), 28'($urandom), $urandom | 32'h1,
                     1'($urandom_range(0, 1)), END_TIMEOUT);
        run_phase(3);

        // No budget at all: the first busy answer already fails.
        next_phase(0, 19, 19);
        run_transfer(1'($urandom_range(0, 1)), 28'($urandom), $urandom | 32'h1,
                     1'($urandom_range(0, 1)), END_TIMEOUT);
        run_phase(3);

        // Small budget; the receiver holds off for a long stretch while a
        // read streams, so the queue fills up and the input stalls.
        next_phase($urandom_range(2, 4), 0, 0);
        pressure_on <= 1'b1;
        run_transfer(1'($urandom_range(0, 1)), 28'($urandom), 32'd1, 1'b0, END_DONE);
        run_phase(2);

        next_phase($urandom_range(5, 65534), 0, 0);
        run_phase(3);

        drain();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
